// File: hw/rtl/drc_pkg.sv
// Shared types and constants for the debounced rotation counter.
// No dependencies; imported by the interfaces, the output buffer and the core.
`default_nettype none

package drc_pkg;

    // Field widths
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 32;
    localparam int DEB_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_PIN_CHANGE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESUME     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SET_COUNT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLR_ROT    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_CLR_ACCEL  = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT = 1'd1;

    localparam logic [DEB_W-1:0] DEBOUNCE_MS_RESET = 16'd10;

    typedef struct packed {
        logic [COUNT_W-1:0]        rotation_count;
        logic [COUNT_W-1:0]        accel_count;
        logic signed [COUNT_W-1:0] distance_total;
        logic                      counted;
        logic                      pin_valid;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/drc_in_if.sv
// Input channel of the debounced rotation counter: valid/ready plus item fields.
// Depends on drc_pkg.
`default_nettype none

interface drc_in_if
    import drc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              pin_level;
    logic              sensing_enabled;
    logic              slow_start;
    logic              resume_from_pause;
    logic [COUNT_W-1:0] preset_count;

    modport source (
        output valid, kind, pin_level, sensing_enabled, slow_start,
               resume_from_pause, preset_count,
        input  ready
    );
    modport sink (
        input  valid, kind, pin_level, sensing_enabled, slow_start,
               resume_from_pause, preset_count,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/drc_out_if.sv
// Result channel of the debounced rotation counter: valid/ready plus result fields.
// Depends on drc_pkg.
`default_nettype none

interface drc_out_if
    import drc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [COUNT_W-1:0]        rotation_count;
    logic [COUNT_W-1:0]        accel_count;
    logic signed [COUNT_W-1:0] distance_total;
    logic                      counted;
    logic                      pin_valid;

    modport source (
        output valid, rotation_count, accel_count, distance_total, counted, pin_valid,
        input  ready
    );
    modport sink (
        input  valid, rotation_count, accel_count, distance_total, counted, pin_valid,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/drc_out_buf.sv
// Two-entry result buffer: decouples the core's result path from downstream stalls.
// Depends on drc_pkg.
`default_nettype none

module drc_out_buf
    import drc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_pop_ready,
    output t_result      o_data
);

    t_result    r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_pop_ready;
    assign o_data  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != 2'd2)
        else $error("push into full result buffer");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("result buffer pointers disagree with count");

endmodule

`default_nettype wire

// File: hw/rtl/debounced_rotation_counter_core.sv
// Top level of the debounced rotation counter: state update, config registers, result buffer.
// Depends on drc_pkg, drc_in_if, drc_out_if and drc_out_buf.
//
//   channel    dir  protocol        carries
//   i_in_ch    in   valid/ready     kind, pin_level, sensing_enabled, slow_start,
//                                   resume_from_pause, preset_count
//   o_out_ch   out  valid/ready     rotation_count, accel_count, distance_total,
//                                   counted, pin_valid
//   i_cfg_*    in   write enable    debounce_ms (index 0), distance_per_count (index 1)
//
// One transaction per cycle while the buffer has space. The state registers update at the
// accept edge and the result enters a two-entry buffer at the same edge, then leaves it behind
// any older results. Synchronous active-low reset clears state, enables edges, restores
// debounce_ms to 10 and distance_per_count to 0, and empties the buffer. When downstream stalls,
// the buffer absorbs up to two results; input ready drops only when both slots are full.
`default_nettype none

module debounced_rotation_counter_core
    import drc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    drc_in_if.sink                     i_in_ch,
    drc_out_if.source                  o_out_ch,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [DEB_W-1:0]   r_debounce_ms;
    logic [COUNT_W-1:0] r_dist_per_count;

    // Block state
    logic [DEB_W-1:0]   r_left;
    logic [COUNT_W-1:0] r_rot;
    logic [COUNT_W-1:0] r_acc;
    logic [COUNT_W-1:0] r_dist;
    logic               r_edges;

    logic [DEB_W-1:0]   n_left;
    logic [COUNT_W-1:0] n_rot;
    logic [COUNT_W-1:0] n_acc;
    logic [COUNT_W-1:0] n_dist;
    logic               n_edges;
    logic               n_counted;

    logic               accept;
    logic               buf_space;
    logic [DEB_W-1:0]   left_dec;
    t_result            res_in;
    t_result            res_out;

    assign accept  = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready = buf_space;
    assign left_dec = r_left - DEB_W'(1);

    // Config writes; the user must write only while the block is idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= DEBOUNCE_MS_RESET;
            r_dist_per_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE_MS:    r_debounce_ms    <= i_cfg_data[DEB_W-1:0];
                REG_DIST_PER_COUNT: r_dist_per_count <= i_cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    // Next state for the transaction on the input
    always_comb begin
        n_left    = r_left;
        n_rot     = r_rot;
        n_acc     = r_acc;
        n_dist    = r_dist;
        n_edges   = r_edges;
        n_counted = 1'b0;
        unique case (i_in_ch.kind)
            KIND_PIN_CHANGE: begin
                // Arm on a qualified high level, cancel otherwise; ignore while edges are off
                if (r_edges) begin
                    if (i_in_ch.pin_level && i_in_ch.sensing_enabled
                        && (r_debounce_ms != '0)) begin
                        n_left = r_debounce_ms;
                    end else begin
                        n_left = '0;
                    end
                end
            end
            KIND_TICK: begin
                // Advance an armed countdown; count on expiry with pin still high
                if (r_left != '0) begin
                    n_left = left_dec;
                    if ((left_dec == '0) && i_in_ch.pin_level) begin
                        n_rot     = r_rot + COUNT_W'(1);
                        n_dist    = r_dist + r_dist_per_count;
                        n_counted = 1'b1;
                        if (i_in_ch.slow_start) begin
                            n_acc = r_acc + COUNT_W'(1);
                        end
                    end
                end
            end
            KIND_START: begin
                n_left  = '0;
                n_rot   = i_in_ch.resume_from_pause ? i_in_ch.preset_count : '0;
                n_edges = 1'b1;
            end
            KIND_STOP: begin
                // Stop only gates edges; an armed countdown keeps running
                n_edges = 1'b0;
            end
            KIND_RESUME: begin
                n_edges = 1'b1;
            end
            KIND_SET_COUNT: begin
                n_rot = i_in_ch.preset_count;
            end
            KIND_CLR_ROT: begin
                n_rot = '0;
            end
            KIND_CLR_ACCEL: begin
                n_acc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_rot   <= '0;
            r_acc   <= '0;
            r_dist  <= '0;
            r_edges <= 1'b1;
        end else if (accept) begin
            r_left  <= n_left;
            r_rot   <= n_rot;
            r_acc   <= n_acc;
            r_dist  <= n_dist;
            r_edges <= n_edges;
        end
    end

    // Result for this transaction goes straight into the buffer
    always_comb begin
        res_in.rotation_count = n_rot;
        res_in.accel_count    = n_acc;
        res_in.distance_total = n_dist;
        res_in.counted        = n_counted;
        res_in.pin_valid      = i_in_ch.pin_level;
    end

    drc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (res_in),
        .o_space     (buf_space),
        .o_valid     (o_out_ch.valid),
        .i_pop_ready (o_out_ch.ready),
        .o_data      (res_out)
    );

    assign o_out_ch.rotation_count = res_out.rotation_count;
    assign o_out_ch.accel_count    = res_out.accel_count;
    assign o_out_ch.distance_total = res_out.distance_total;
    assign o_out_ch.counted        = res_out.counted;
    assign o_out_ch.pin_valid      = res_out.pin_valid;

    a_count_on_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && n_counted |-> r_left == DEB_W'(1))
        else $error("rotation counted without countdown expiring");

    a_idle_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_ch.kind == KIND_TICK) && (r_left == '0)
        |=> $stable(r_rot) && $stable(r_dist) && $stable(r_acc) && (r_left == '0))
        else $error("idle tick changed state");

    a_start_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_ch.kind == KIND_START) |=> (r_left == '0) && r_edges)
        else $error("start did not cancel countdown and enable edges");

    a_stop_gates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_ch.kind == KIND_STOP) |=> !r_edges && $stable(r_left))
        else $error("stop changed the countdown or left edges on");

endmodule

`default_nettype wire
